### rtl/core/rde_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rde_pkg: shared types and constants of the radix digit emitter
// Controller states, command and status bundles, register indexes and
// register reset values.
// ---------------------------------------------------------------------------
package rde_pkg;

	localparam int CHAR_BITS = 8;
	localparam int RADIX_BITS = 5;
	localparam int DIGIT_BITS = 4;
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS = 64;
	localparam int SLICE_BITS = 8;

	localparam logic [CFG_INDEX_BITS-1:0] CFG_RADIX = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_CHARS_LOW = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_CHARS_HIGH = 2'd2;

	localparam logic [RADIX_BITS-1:0] RADIX_MIN = 5'd2;
	localparam logic [RADIX_BITS-1:0] RADIX_MAX = 5'd16;
	localparam logic [RADIX_BITS-1:0] RADIX_RESET = 5'd16;
	localparam logic [CFG_DATA_BITS-1:0] CHARS_LOW_RESET = 64'h3736_3534_3332_3130;
	localparam logic [CFG_DATA_BITS-1:0] CHARS_HIGH_RESET = 64'h6665_6463_6261_3938;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_FIRST,
		ST_OUT
	} rde_state_t;

	typedef struct packed {
		logic load;
		logic div_step;
		logic rd_first;
		logic rd_next;
		logic out_valid;
	} rde_cmd_t;

	typedef struct packed {
		logic inbuf_valid;
		logic step_last;
		logic quot_zero;
		logic cnt_last;
		logic pos_zero;
	} rde_status_t;

endpackage

### rtl/core/rde_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rde_ctrl: conversion sequencer
// Steps through load, digit division, first store read and digit emission.
// ---------------------------------------------------------------------------
module rde_ctrl
	import rde_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  rde_status_t status,
	input  logic        out_ready,
	output rde_cmd_t    cmd
);

	rde_state_t state_q;
	rde_state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (status.inbuf_valid) state_next = ST_DIV;
			end
			ST_DIV: begin
				if (status.step_last && (status.quot_zero || status.cnt_last)) begin
					state_next = ST_FIRST;
				end
			end
			ST_FIRST: begin
				state_next = ST_OUT;
			end
			ST_OUT: begin
				if (out_ready && status.pos_zero) state_next = ST_IDLE;
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.load = status.inbuf_valid;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
			end
			ST_FIRST: begin
				cmd.rd_first = 1'b1;
			end
			ST_OUT: begin
				cmd.out_valid = 1'b1;
				cmd.rd_next = out_ready && !status.pos_zero;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

### rtl/core/rde_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rde_datapath: registers, divider slice and digit store
// Holds configuration, the input buffer, the working quotient with its
// byte-per-cycle long division by the radix, and the digit store.
// ---------------------------------------------------------------------------
module rde_datapath
	import rde_pkg::*;
#(
	parameter int VALUE_BITS = 32,
	parameter int MAX_DIGITS = 32,
	parameter int IN_BITS = 40
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [IN_BITS-1:0]        s_tdata,
	input  logic                      cfg_valid,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	input  rde_cmd_t                  cmd,
	output rde_status_t               status,
	output logic [CHAR_BITS-1:0]      out_char,
	output logic                      out_last
);

	localparam int DIV_STEPS = (VALUE_BITS + SLICE_BITS - 1) / SLICE_BITS;
	localparam int PAD_BITS = DIV_STEPS * SLICE_BITS;
	localparam int SW = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
	localparam int AW = $clog2(MAX_DIGITS);
	localparam int CW = $clog2(MAX_DIGITS + 1);

	logic [RADIX_BITS-1:0]    radix_q;
	logic [CFG_DATA_BITS-1:0] chars_low_q;
	logic [CFG_DATA_BITS-1:0] chars_high_q;
	logic [VALUE_BITS-1:0]    inbuf_q;
	logic                     inbuf_valid_q;
	logic [PAD_BITS-1:0]      qr_q;
	logic [DIGIT_BITS-1:0]    rem_q;
	logic [SW-1:0]            step_q;
	logic [CW-1:0]            cnt_q;
	logic [AW-1:0]            pos_q;
	logic [DIGIT_BITS-1:0]    rd_data_q;
	logic [DIGIT_BITS-1:0]    mem [MAX_DIGITS];

	logic [RADIX_BITS-1:0]              radix_eff;
	logic [DIGIT_BITS+SLICE_BITS-1:0]   slice_res;
	logic [DIGIT_BITS-1:0]              rem_next;
	logic [PAD_BITS+SLICE_BITS-1:0]     qr_wide;
	logic [PAD_BITS-1:0]                qr_next;
	logic [CW-1:0]                      cnt_m1;
	logic                               step_last;
	logic                               rd_en;
	logic [AW-1:0]                      rd_addr;
	logic [2*CFG_DATA_BITS-1:0]         char_tbl;

	// Restoring long division of one byte by the radix, MSB first.
	function automatic logic [DIGIT_BITS+SLICE_BITS-1:0] div_slice(
		input logic [DIGIT_BITS-1:0] rem_in,
		input logic [SLICE_BITS-1:0] slice_in,
		input logic [RADIX_BITS-1:0] dvs
	);
		logic [RADIX_BITS-1:0] t;
		logic [DIGIT_BITS-1:0] r;
		logic [SLICE_BITS-1:0] qb;
		r = rem_in;
		qb = '0;
		for (int i = SLICE_BITS - 1; i >= 0; i--) begin
			t = {r, slice_in[i]};
			if (t >= dvs) begin
				r = DIGIT_BITS'(t - dvs);
				qb[i] = 1'b1;
			end else begin
				r = t[DIGIT_BITS-1:0];
			end
		end
		return {r, qb};
	endfunction

	always_comb begin
		if (radix_q < RADIX_MIN) begin
			radix_eff = RADIX_MIN;
		end else if (radix_q > RADIX_MAX) begin
			radix_eff = RADIX_MAX;
		end else begin
			radix_eff = radix_q;
		end
	end

	assign slice_res = div_slice(rem_q, qr_q[PAD_BITS-1 -: SLICE_BITS], radix_eff);
	assign rem_next = slice_res[DIGIT_BITS+SLICE_BITS-1:SLICE_BITS];
	assign qr_wide = {qr_q, slice_res[SLICE_BITS-1:0]};
	assign qr_next = qr_wide[PAD_BITS-1:0];
	assign step_last = (step_q == SW'(DIV_STEPS - 1));
	assign cnt_m1 = cnt_q - CW'(1);

	assign s_tready = !inbuf_valid_q;

	assign status.inbuf_valid = inbuf_valid_q;
	assign status.step_last = step_last;
	assign status.quot_zero = (qr_next == '0);
	assign status.cnt_last = (cnt_q == CW'(MAX_DIGITS - 1));
	assign status.pos_zero = (pos_q == '0);

	// Configuration registers; an index beyond the list is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
			chars_low_q <= CHARS_LOW_RESET;
			chars_high_q <= CHARS_HIGH_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_RADIX: radix_q <= cfg_data[RADIX_BITS-1:0];
				CFG_CHARS_LOW: chars_low_q <= cfg_data;
				CFG_CHARS_HIGH: chars_high_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inbuf_valid_q <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			inbuf_valid_q <= 1'b1;
		end else if (cmd.load) begin
			inbuf_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) inbuf_q <= s_tdata[VALUE_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qr_q <= '0;
			rem_q <= '0;
			step_q <= '0;
			cnt_q <= '0;
			pos_q <= '0;
		end else begin
			if (cmd.load) begin
				qr_q <= PAD_BITS'(inbuf_q);
				rem_q <= '0;
				step_q <= '0;
				cnt_q <= '0;
			end else if (cmd.div_step) begin
				qr_q <= qr_next;
				if (step_last) begin
					rem_q <= '0;
					step_q <= '0;
					cnt_q <= cnt_q + CW'(1);
				end else begin
					rem_q <= rem_next;
					step_q <= step_q + SW'(1);
				end
			end
			if (cmd.rd_first) begin
				pos_q <= cnt_m1[AW-1:0];
			end else if (cmd.rd_next) begin
				pos_q <= pos_q - AW'(1);
			end
		end
	end

	assign rd_en = cmd.rd_first || cmd.rd_next;
	assign rd_addr = cmd.rd_first ? cnt_m1[AW-1:0] : pos_q - AW'(1);

	always_ff @(posedge clk) begin
		if (cmd.div_step && step_last) mem[cnt_q[AW-1:0]] <= rem_next;
	end

	always_ff @(posedge clk) begin
		if (rd_en) rd_data_q <= mem[rd_addr];
	end

	assign char_tbl = {chars_high_q, chars_low_q};
	assign out_char = char_tbl[{rd_data_q, 3'b000} +: CHAR_BITS];
	assign out_last = (pos_q == '0);

endmodule

### rtl/core/radix_digit_emitter.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// radix_digit_emitter: integer to digit characters in a configurable radix
// Top level: stream ports, configuration port, controller and datapath.
// ---------------------------------------------------------------------------
// Each transfer on the input stream carries one integer; the block answers
// with its digits in the configured radix, most significant first, one
// character per output transfer, with tlast on the final digit. A negative
// input converts as its low VALUE_BITS bits. Radix values below two act as
// two and values above sixteen as sixteen; the characters come from the two
// table registers, digit value 0 in the lowest byte. Zero gives the single
// character of digit 0. A value that needs more than MAX_DIGITS digits gives
// only its lowest MAX_DIGITS digits. Each item is loaded, then divided digit
// by digit (the divider clears one byte of the working quotient per cycle),
// then the first digit is read from the store, and then the digits go out
// one per transfer while the sink is ready. The input buffer takes the next
// integer while the current one is still converting or emitting. Write
// configuration only while idle.
// ---------------------------------------------------------------------------
module radix_digit_emitter
	import rde_pkg::*;
#(
	parameter int VALUE_BITS = 32,
	parameter int MAX_DIGITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// value (VALUE_BITS+1 bits, signed), zero padded to whole bytes
	input  logic [((VALUE_BITS+8)/8)*8-1:0]     s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// digit_char (8 bits)
	output logic [CHAR_BITS-1:0]                m_tdata,
	output logic                                m_tlast,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0]           cfg_index,
	input  logic [CFG_DATA_BITS-1:0]            cfg_data
);

	localparam int IN_BITS = ((VALUE_BITS + 8) / 8) * 8;

	rde_cmd_t    cmd;
	rde_status_t status;

	// Configuration writes are registered on the transfer, so the port never stalls.
	assign cfg_ready = 1'b1;

	rde_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.status    (status),
		.out_ready (m_tready),
		.cmd       (cmd)
	);

	rde_datapath #(
		.VALUE_BITS (VALUE_BITS),
		.MAX_DIGITS (MAX_DIGITS),
		.IN_BITS    (IN_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status),
		.out_char  (m_tdata),
		.out_last  (m_tlast)
	);

	assign m_tvalid = cmd.out_valid;

	// After the final digit the block must pass through load and divide.
	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> !m_tvalid)
		else $error("output valid right after the final digit");

	// The divider never runs while a digit is on offer.
	a_no_div_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> !m_tvalid)
		else $error("division step while a digit is offered");

	// A load only takes a buffered integer.
	a_load_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> status.inbuf_valid)
		else $error("load without a buffered item");

	// An input transfer fills the buffer, so the next cycle cannot take one.
	a_buffer_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input ready right after an input transfer");

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: self-checking bench for the radix digit emitter
// Walks a short table of directed conversions and register writes, then runs
// random phases with fresh radix and character tables. Integers sent without
// typed digits are converted by a local digit predictor, and each output
// transfer is checked against the oldest pending digit, character and tlast.
// ---------------------------------------------------------------------------
module testbench
	import rde_pkg::*;
();

	localparam int VALUE_BITS = 32;
	localparam int MAX_DIGITS = 32;
	localparam int TDATA_BITS = ((VALUE_BITS + 8) / 8) * 8;
	localparam real HALF_PERIOD = 6.0;
	localparam int RESET_CYCLES = 11;
	// bound on the run: about 325 values of up to 32 digits, with sink stalls
	localparam int CYCLE_LIMIT = 2000000;
	// tail long enough for the longest conversion
	localparam int TAIL_CYCLES = 170;
	localparam int REPORT_LIMIT = 10;
	localparam int RANDOM_PHASES = 10;
	localparam int PHASE_VALUES = 30;
	localparam int QUIET_PHASES = 2;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED = 2'd3;
	localparam logic [255:0] NO_TEXT = '0;

	typedef enum logic {
		ROW_CFG,
		ROW_VALUE
	} row_kind_t;

	// one directed step: a register write or a value, with typed digits where
	// they are obvious (text of zero means the predictor decides)
	typedef struct packed {
		row_kind_t                 kind;
		logic [CFG_INDEX_BITS-1:0] index;
		logic [CFG_DATA_BITS-1:0]  data;
		logic [VALUE_BITS:0]       value;
		logic [255:0]              text;
	} stim_row_t;

	typedef struct packed {
		logic                 last;
		logic [CHAR_BITS-1:0] char_code;
	} digit_t;

	logic                      clk;
	logic                      arst_n;
	logic                      s_tvalid;
	logic                      s_tready;
	// value (33 bits, signed), zero padded to 40 bits
	logic [TDATA_BITS-1:0]     s_tdata;
	logic                      m_tvalid;
	logic                      m_tready;
	// digit_char (8 bits)
	logic [CHAR_BITS-1:0]      m_tdata;
	logic                      m_tlast;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0]  cfg_data;

	// shadow copy of the configuration registers
	logic [RADIX_BITS-1:0]     base_reg;
	logic [CFG_DATA_BITS-1:0]  glyphs_low;
	logic [CFG_DATA_BITS-1:0]  glyphs_high;

	digit_t    pending_digits[$];
	stim_row_t stim_table[$];

	int  fail_count;
	int  cycle_count;
	int  values_sent;
	int  digits_seen;
	int  reg_writes;
	bit  idle_on;
	int  sink_hold;

	radix_digit_emitter #(
		.VALUE_BITS(VALUE_BITS),
		.MAX_DIGITS(MAX_DIGITS)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial clk = 1'b0;
	always #(HALF_PERIOD) clk = ~clk;

	// Watchdog: a stuck handshake ends the run here.
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d digits still pending",
				cycle_count, pending_digits.size());
			$display("status: fail");
			$finish;
		end
	end

	// Character of one digit value from the shadow tables.
	function automatic logic [CHAR_BITS-1:0] glyph_of(input logic [DIGIT_BITS-1:0] d);
		if (d < 8)
			return glyphs_low[d[2:0]*8 +: 8];
		return glyphs_high[d[2:0]*8 +: 8];
	endfunction

	// Predictor: convert the low 32 bits of the value, most significant digit
	// first, and queue one expected transfer per digit.
	function automatic void convert_to_digits(input logic [VALUE_BITS:0] value);
		logic [VALUE_BITS-1:0] quot;
		logic [VALUE_BITS-1:0] base;
		logic [DIGIT_BITS-1:0] store[MAX_DIGITS];
		int                    n;
		digit_t                d;
		base = VALUE_BITS'(base_reg);
		if (base < RADIX_MIN)
			base = RADIX_MIN;
		if (base > RADIX_MAX)
			base = RADIX_MAX;
		quot = value[VALUE_BITS-1:0];
		n = 0;
		// saturate at MAX_DIGITS, keeping the least significant digits
		do begin
			store[n] = DIGIT_BITS'(quot % base);
			n++;
			quot = quot / base;
		end while (quot != 0 && n < MAX_DIGITS);
		for (int k = n - 1; k >= 0; k--) begin
			d.last = (k == 0);
			d.char_code = glyph_of(store[k]);
			pending_digits.push_back(d);
		end
	endfunction

	// Queue typed digits: the string is right aligned, leading zero bytes skipped.
	function automatic void queue_text(input logic [255:0] text);
		int     top;
		digit_t d;
		top = 31;
		while (top > 0 && text[top*8 +: 8] == 8'h00)
			top--;
		for (int k = top; k >= 0; k--) begin
			d.last = (k == 0);
			d.char_code = text[k*8 +: 8];
			pending_digits.push_back(d);
		end
	endfunction

	function automatic void table_cfg(input logic [CFG_INDEX_BITS-1:0] index,
			input logic [CFG_DATA_BITS-1:0] data);
		stim_row_t row;
		row = '0;
		row.kind = ROW_CFG;
		row.index = index;
		row.data = data;
		stim_table.push_back(row);
	endfunction

	function automatic void table_value(input logic [VALUE_BITS:0] value,
			input logic [255:0] text);
		stim_row_t row;
		row = '0;
		row.kind = ROW_VALUE;
		row.value = value;
		row.text = text;
		stim_table.push_back(row);
	endfunction

	// Mix of short, full-width, negative and below-range values.
	function automatic logic [VALUE_BITS:0] random_value();
		case ($urandom_range(0, 3))
			0: return {1'b0, 32'($urandom_range(0, 5000))};
			1: return {1'b0, 32'($urandom)};
			2: return {2'b11, 31'($urandom)};
			default: return {1'($urandom), 32'($urandom)};
		endcase
	endfunction

	// Write one register; update the shadow on the transfer.
	// Called at a falling edge, returns at a falling edge.
	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] index,
			input logic [CFG_DATA_BITS-1:0] data);
		cfg_valid = 1'b1;
		cfg_index = index;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		case (index)
			CFG_RADIX:      base_reg = data[RADIX_BITS-1:0];
			CFG_CHARS_LOW:  glyphs_low = data;
			CFG_CHARS_HIGH: glyphs_high = data;
			default: ;  // unused index: the block ignores it
		endcase
		reg_writes++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Send one value, optionally after an idle burst. On the transfer queue
	// either the typed digits or the predicted ones.
	task automatic send_value(input logic [VALUE_BITS:0] value, input logic [255:0] text);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = TDATA_BITS'(value);
		do @(posedge clk); while (!s_tready);
		if (text != NO_TEXT)
			queue_text(text);
		else
			convert_to_digits(value);
		values_sent++;
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	// Hold off until every pending digit has arrived, then let the block settle.
	task automatic drain();
		while (pending_digits.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Sink: drop tready for random bursts while idling is on.
	initial begin
		sink_hold = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (sink_hold > 0) begin
				sink_hold--;
				m_tready = 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				sink_hold = $urandom_range(1, 19) - 1;
				m_tready = 1'b0;
			end else begin
				m_tready = 1'b1;
			end
		end
	end

	// Checker: compare each output transfer with the oldest pending digit.
	always @(posedge clk) begin
		digit_t exp_digit;
		if (arst_n && m_tvalid && m_tready) begin
			digits_seen++;
			if (pending_digits.size() == 0) begin
				fail_count++;
				if (fail_count <= REPORT_LIMIT)
					$display("unexpected transfer: char %02h last %0d", m_tdata, m_tlast);
			end else begin
				exp_digit = pending_digits.pop_front();
				if (m_tdata !== exp_digit.char_code || m_tlast !== exp_digit.last) begin
					fail_count++;
					if (fail_count <= REPORT_LIMIT)
						$display("mismatch: char exp %02h got %02h, last exp %0d got %0d",
							exp_digit.char_code, m_tdata, exp_digit.last, m_tlast);
				end
			end
		end
	end

	initial begin
		fail_count = 0;
		values_sent = 0;
		digits_seen = 0;
		reg_writes = 0;
		idle_on = 1'b1;
		base_reg = RADIX_RESET;
		glyphs_low = CHARS_LOW_RESET;
		glyphs_high = CHARS_HIGH_RESET;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_RADIX;
		cfg_data = '0;

		// Directed table: reset defaults first, then decimal, radix clamping, the
		// ignored index, and custom and extreme character tables.
		table_value(33'h0_0000_0000, "0");
		table_value(33'h0_0000_0001, "1");
		table_value(33'h0_FFFF_FFFF, "ffffffff");
		table_value(33'h1_FFFF_FFFF, "ffffffff");
		table_value(33'h1_8000_0000, "80000000");
		table_value(33'h1_0000_0000, "0");           // below range: wraps
		table_value(33'h1_2345_6789, "23456789");    // below range: low bits
		table_cfg(CFG_RADIX, 64'd10);
		table_value(33'h0_FFFF_FFFF, "4294967295");
		table_value(33'h0_0000_0000, "0");
		table_value(33'h1_FFFF_FFFF, "4294967295");
		table_cfg(CFG_RADIX, 64'd0);                  // acts as two
		table_value(33'h0_0000_0005, "101");
		table_value(33'h0_FFFF_FFFF, "11111111111111111111111111111111");
		table_cfg(CFG_RADIX, 64'd1);                  // acts as two
		table_value(33'h0_0000_0002, "10");
		table_cfg(CFG_RADIX, 64'd17);                 // acts as sixteen
		table_value(33'h0_DEAD_BEEF, "deadbeef");
		table_cfg(CFG_RADIX, 64'h1F);                 // acts as sixteen
		table_value(33'h0_0000_1000, "1000");
		table_cfg(CFG_UNUSED, 64'd3);                 // no register behind it
		table_value(33'h0_0000_00AB, "ab");
		table_cfg(CFG_CHARS_LOW, 64'h4847_4645_4443_4241);
		table_cfg(CFG_CHARS_HIGH, 64'h504F_4E4D_4C4B_4A49);
		table_value(33'h0_0123_4567, "BCDEFGH");
		table_value(33'h0_89AB_CDEF, "IJKLMNOP");
		table_value(33'h0_0000_0000, "A");
		table_cfg(CFG_CHARS_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
		table_cfg(CFG_CHARS_HIGH, 64'h0);
		table_value(33'h0_F0F0_1234, NO_TEXT);
		table_cfg(CFG_RADIX, 64'd3);
		table_value(33'h0_FFFF_FFFF, NO_TEXT);
		table_cfg(CFG_RADIX, 64'd7);
		table_value(33'h1_0000_3039, NO_TEXT);

		// Hold reset, then release it at a falling edge.
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// Walk the table; drain before every register write.
		foreach (stim_table[i]) begin
			if (stim_table[i].kind == ROW_CFG) begin
				drain();
				write_reg(stim_table[i].index, stim_table[i].data);
			end else begin
				send_value(stim_table[i].value, stim_table[i].text);
			end
		end

		// Random phases: a fresh setting each time, the sender paused until
		// the block is empty in between. The last phases run without idling.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			drain();
			if (p >= RANDOM_PHASES - QUIET_PHASES)
				idle_on = 1'b0;
			if (p == 0) begin
				write_reg(CFG_RADIX, 64'(RADIX_RESET));
				write_reg(CFG_CHARS_LOW, CHARS_LOW_RESET);
				write_reg(CFG_CHARS_HIGH, CHARS_HIGH_RESET);
			end else begin
				write_reg(CFG_RADIX, 64'($urandom_range(0, 31)));
				write_reg(CFG_CHARS_LOW, {32'($urandom), 32'($urandom)});
				write_reg(CFG_CHARS_HIGH, {32'($urandom), 32'($urandom)});
			end
			for (int k = 0; k < PHASE_VALUES; k++)
				send_value(random_value(), NO_TEXT);
		end

		// Wait out the pending digits, then a tail to catch stray transfers.
		drain();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (pending_digits.size() != 0) begin
			fail_count++;
			$display("%0d digits never arrived", pending_digits.size());
		end

		$display("converted %0d values into %0d digit transfers over %0d register writes",
			values_sent, digits_seen, reg_writes);
		$display("radix settings spanned clamped, decimal, binary and random tables; %0d errors",
			fail_count);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

### sim.f
rtl/core/rde_pkg.sv
rtl/core/rde_ctrl.sv
rtl/core/rde_datapath.sv
rtl/core/radix_digit_emitter.sv
verif/testbench.sv
